/* rtl/encoder_period_tachometer_assert.svh */
// ----------------------------------------------------------------------------
// Encoder period tachometer assertion macros
// Shared concurrent assertion forms, clocked on clk_i and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ENCODER_PERIOD_TACHOMETER_ASSERT_SVH
`define ENCODER_PERIOD_TACHOMETER_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define ETP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define ETP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/etp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etp_pkg
// Widths, reset values, codes and shared types of the encoder tachometer.
// ----------------------------------------------------------------------------
package etp_pkg;

  localparam int TIME_W     = 32;
  localparam int SPEED_W    = 24;
  localparam int NUM_W      = 26;
  localparam int SAMP_W     = 6;
  localparam int FRAC_W     = 8;
  localparam int AVG_DEPTH  = 32;

  localparam int IDX_W      = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int CNT_W      = $clog2(AVG_DEPTH + 1);
  localparam int SUM_W      = SPEED_W + CNT_W;

  localparam int DVD_W      = NUM_W + FRAC_W;
  localparam int DVS_W      = TIME_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int S_TDATA_W  = 32;
  localparam int OUT_BITS   = 2 * SPEED_W + 4 * TIME_W + 1;
  localparam int M_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

  localparam logic [TIME_W-1:0] MIN_INT_RST  = 32'd17;
  localparam logic [TIME_W-1:0] MAX_INT_RST  = 32'd1000000;
  localparam logic [TIME_W-1:0] TIMEOUT_RST  = 32'd500000;
  localparam logic [NUM_W-1:0]  NUMER_RST    = 26'd30000;
  localparam logic [SAMP_W-1:0] SAMPLES_RST  = 6'd5;
  localparam logic [TIME_W-1:0] WINDOW_RST   = 32'd1000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_INTERVAL = 3'd0,
    REG_MAX_INTERVAL = 3'd1,
    REG_TIMEOUT      = 3'd2,
    REG_RPM_NUMER    = 3'd3,
    REG_AVG_SAMPLES  = 3'd4,
    REG_WINDOW       = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_EDGE_DIV,
    ST_STROBE,
    ST_MOD,
    ST_SUM,
    ST_AVG_DIV,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quot;
  } div_rsp_t;

endpackage

/* rtl/encoder_period_tachometer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_period_tachometer
// Encoder period tachometer with a moving average over a speed ring in RAM.
// ----------------------------------------------------------------------------
//  Channel   Direction  Word contents
//  s_axis    in         tuser: mode; tdata: now_us
//  m_axis    out        tdata: inst_rpm .. pulse_live (one word per input)
//  cfg       in         write enable, register index, write data
//
//  An edge word with an accepted nonzero interval waits on the speed divider,
//  which yields one quotient bit per cycle over 34 bits; other edge words skip
//  it. A strobe word writes the ring, then wraps the ring pointer in subtract
//  steps (one at a plain wrap, more after the sample count shrinks), reads the
//  averaged ring entries (one RAM read per cycle) and divides their sum.
//  Reset is asynchronous; ring entries carry valid bits, so no clearing pass.
//  A new word is accepted while the last result waits on m_axis.
// ----------------------------------------------------------------------------
module encoder_period_tachometer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Slave stream, tdata: now_us [31:0]; tuser: mode [0]
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [etp_pkg::S_TDATA_W-1:0]    s_axis_tdata_i,
  input  logic                             s_axis_tuser_i,
  // Master stream, tdata: inst_rpm [23:0], avg_rpm [47:24],
  // interval_us [79:48], pulse_total [111:80], bad_intervals [143:112],
  // window_pulses [175:144], pulse_live [176], zero fill above
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [etp_pkg::M_TDATA_W-1:0]    m_axis_tdata_o,
  // Configuration write port
  input  logic                             cfg_we_i,
  input  logic [etp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [etp_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import etp_pkg::*;

  // Configuration registers
  logic [TIME_W-1:0] min_int_q, max_int_q, timeout_q, window_q;
  logic [NUM_W-1:0]  numer_q;
  logic [SAMP_W-1:0] samples_cfg_q;

  // Scalar tachometer state
  logic [TIME_W-1:0]  prev_edge_q, last_int_q, valid_time_q;
  logic [TIME_W-1:0]  edge_total_q, reject_total_q, rate_count_q, rate_start_q;
  logic               seen_edge_q;
  logic [SPEED_W-1:0] speed_now_q, speed_avg_q;
  logic [IDX_W-1:0]   ring_pos_q;
  logic               ring_full_q;
  logic [AVG_DEPTH-1:0] ring_vld_q;

  // Sequencer
  state_e             state_q, state_d;
  logic [TIME_W-1:0]  now_q;
  logic [CNT_W-1:0]   pos_nxt_q;
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   walk_q;
  logic               pend_q;
  logic               rd_vld_q;
  logic [SUM_W-1:0]   sum_q;

  // Output register
  logic                 m_tvalid_q;
  logic [M_TDATA_W-1:0] m_tdata_q;

  // Datapath signals
  logic [TIME_W-1:0]  dt;
  logic               in_window;
  logic               rate_expired;
  logic               timed_out;
  logic [CNT_W-1:0]   samples;
  logic               walk_more;
  logic               full_next;
  logic [CNT_W-1:0]   count_next;
  logic [SPEED_W-1:0] ring_wdata;
  logic [SPEED_W-1:0] ring_rdata;
  logic [SPEED_W-1:0] ring_rdata_m;
  logic               out_free;
  logic               s_accept;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_tvalid_q || m_axis_tready_i;

  always_comb begin
    dt           = now_q - prev_edge_q;
    in_window    = seen_edge_q && (dt >= min_int_q) && (dt <= max_int_q);
    rate_expired = ((now_q - rate_start_q) >= window_q);
    timed_out    = ((now_q - valid_time_q) > timeout_q);
    ring_wdata   = timed_out ? '0 : speed_now_q;
    walk_more    = (walk_q < count_q);
    full_next    = ring_full_q || (pos_nxt_q == '0);
    count_next   = full_next ? samples : pos_nxt_q;
    ring_rdata_m = ring_rdata & {SPEED_W{rd_vld_q}};
  end

  // Sample count clamped to the ring depth, never below one.
  always_comb begin
    if (samples_cfg_q == '0) begin
      samples = CNT_W'(1);
    end else if (32'(samples_cfg_q) > AVG_DEPTH) begin
      samples = CNT_W'(AVG_DEPTH);
    end else begin
      samples = CNT_W'(samples_cfg_q);
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_int_q     <= MIN_INT_RST;
      max_int_q     <= MAX_INT_RST;
      timeout_q     <= TIMEOUT_RST;
      numer_q       <= NUMER_RST;
      samples_cfg_q <= SAMPLES_RST;
      window_q      <= WINDOW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN_INTERVAL: min_int_q     <= cfg_data_i[TIME_W-1:0];
        REG_MAX_INTERVAL: max_int_q     <= cfg_data_i[TIME_W-1:0];
        REG_TIMEOUT:      timeout_q     <= cfg_data_i[TIME_W-1:0];
        REG_RPM_NUMER:    numer_q       <= cfg_data_i[NUM_W-1:0];
        REG_AVG_SAMPLES:  samples_cfg_q <= cfg_data_i[SAMP_W-1:0];
        REG_WINDOW:       window_q      <= cfg_data_i[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state and divider requests
  always_comb begin
    state_d          = state_q;
    div_req.start    = 1'b0;
    div_req.dividend = {numer_q, {FRAC_W{1'b0}}};
    div_req.divisor  = dt;
    unique case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          state_d = s_axis_tuser_i ? ST_STROBE : ST_EDGE;
        end
      end
      ST_EDGE: begin
        if (in_window && (dt != '0)) begin
          div_req.start = 1'b1;
          state_d       = ST_EDGE_DIV;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_EDGE_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_FINISH;
        end
      end
      ST_STROBE: begin
        state_d = ST_MOD;
      end
      ST_MOD: begin
        if (pos_nxt_q < samples) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        div_req.dividend = {{(DVD_W - SUM_W){1'b0}}, sum_q};
        div_req.divisor  = {{(DVS_W - CNT_W){1'b0}}, count_q};
        if (!walk_more && !pend_q) begin
          if (count_q == '0) begin
            state_d = ST_FINISH;
          end else begin
            div_req.start = 1'b1;
            state_d       = ST_AVG_DIV;
          end
        end
      end
      ST_AVG_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Tachometer state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_edge_q    <= '0;
      seen_edge_q    <= 1'b0;
      last_int_q     <= '0;
      speed_now_q    <= '0;
      valid_time_q   <= '0;
      edge_total_q   <= '0;
      reject_total_q <= '0;
      rate_count_q   <= '0;
      rate_start_q   <= '0;
      ring_pos_q     <= '0;
      ring_full_q    <= 1'b0;
      ring_vld_q     <= '0;
      speed_avg_q    <= '0;
      walk_q         <= '0;
      pend_q         <= 1'b0;
      m_tvalid_q     <= 1'b0;
    end else begin
      if ((state_q == ST_FINISH) && out_free) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        ST_EDGE: begin
          edge_total_q <= edge_total_q + 32'd1;
          if (in_window) begin
            last_int_q   <= dt;
            valid_time_q <= now_q;
            if (dt == '0) begin
              speed_now_q <= SPEED_MAX;
            end
          end else if (seen_edge_q) begin
            reject_total_q <= reject_total_q + 32'd1;
          end
          prev_edge_q <= now_q;
          seen_edge_q <= 1'b1;
          if (rate_expired) begin
            rate_count_q <= 32'd1;
            rate_start_q <= now_q;
          end else begin
            rate_count_q <= rate_count_q + 32'd1;
          end
        end
        ST_EDGE_DIV: begin
          if (div_rsp.done) begin
            speed_now_q <= (|div_rsp.quot[DVD_W-1:SPEED_W]) ? SPEED_MAX
                                                              : div_rsp.quot[SPEED_W-1:0];
          end
        end
        ST_STROBE: begin
          speed_now_q            <= ring_wdata;
          ring_vld_q[ring_pos_q] <= 1'b1;
        end
        ST_MOD: begin
          if (pos_nxt_q < samples) begin
            ring_pos_q  <= pos_nxt_q[IDX_W-1:0];
            ring_full_q <= full_next;
            walk_q      <= '0;
            pend_q      <= 1'b0;
          end
        end
        ST_SUM: begin
          // One ring read issued per cycle; pend_q marks the read whose registered data is summed.
          pend_q <= walk_more;
          if (walk_more) begin
            walk_q <= walk_q + CNT_W'(1);
          end
          if (!walk_more && !pend_q && (count_q == '0)) begin
            speed_avg_q <= '0;
          end
        end
        ST_AVG_DIV: begin
          if (div_rsp.done) begin
            speed_avg_q <= div_rsp.quot[SPEED_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      now_q <= s_axis_tdata_i[TIME_W-1:0];
    end
    if (state_q == ST_STROBE) begin
      pos_nxt_q <= CNT_W'(ring_pos_q) + CNT_W'(1);
    end else if (state_q == ST_MOD) begin
      // The sample count may have shrunk, so the pointer wraps by subtraction.
      if (pos_nxt_q >= samples) begin
        pos_nxt_q <= pos_nxt_q - samples;
      end else begin
        count_q <= count_next;
        sum_q   <= '0;
      end
    end else if (state_q == ST_SUM) begin
      if (walk_more) begin
        rd_vld_q <= ring_vld_q[walk_q[IDX_W-1:0]];
      end
      if (pend_q) begin
        sum_q <= sum_q + {{(SUM_W - SPEED_W){1'b0}}, ring_rdata_m};
      end
    end
    if ((state_q == ST_FINISH) && out_free) begin
      m_tdata_q <= {{(M_TDATA_W - OUT_BITS){1'b0}},
                    !timed_out,
                    rate_count_q,
                    reject_total_q,
                    edge_total_q,
                    last_int_q,
                    speed_avg_q,
                    speed_now_q};
    end
  end

  etp_ram #(
    .WIDTH (SPEED_W),
    .DEPTH (AVG_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_STROBE),
    .waddr_i (ring_pos_q),
    .wdata_i (ring_wdata),
    .re_i    ((state_q == ST_SUM) && walk_more),
    .raddr_i (walk_q[IDX_W-1:0]),
    .rdata_o (ring_rdata)
  );

  etp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;

`include "encoder_period_tachometer_assert.svh"

  `ETP_ASSERT(a_div_done_state, div_rsp.done |-> (state_q == ST_EDGE_DIV || state_q == ST_AVG_DIV), "divider finished outside a divide state")
  `ETP_ASSERT(a_div_busy_state, div_rsp.busy |-> (state_q == ST_EDGE_DIV || state_q == ST_AVG_DIV), "divider busy outside a divide state")
  `ETP_ASSERT(a_walk_bound, (state_q == ST_SUM) |-> (walk_q <= count_q), "ring walk ran past the sample count")
  `ETP_ASSERT_NEXT(a_result_loaded, (state_q == ST_FINISH) && out_free, m_tvalid_q && (state_q == ST_IDLE), "finished result was not presented")

endmodule

/* rtl/etp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etp_ram
// Generic single write, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module etp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/etp_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etp_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module etp_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  etp_pkg::div_req_t req_i,
  output etp_pkg::div_rsp_t rsp_o
);
  import etp_pkg::*;

  localparam int STEP_W = $clog2(DVD_W);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVD_W-1:0]  quo_q;
  logic [DVS_W-1:0]  dvs_q;

  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              fits;
  logic [DVS_W-1:0]  rem_next;

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  always_comb begin
    trial    = {rem_q, quo_q[DVD_W-1]};
    diff     = trial - {1'b0, dvs_q};
    fits     = (trial >= {1'b0, dvs_q});
    rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + STEP_W'(1);
      if (step_q == STEP_W'(DVD_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_next;
      quo_q <= {quo_q[DVD_W-2:0], fits};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

/* bench/encoder_period_tachometer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_period_tachometer_tb
// Self-checking bench for the encoder tachometer. Edge and strobe words go
// in through the input stream with random bursts and gaps. The output stream
// stalls on its own random pattern. Every result word is compared field by
// field with the values of a behavioral tachometer kept in the bench. Phases
// change the registers between runs, the extremes included.
// ----------------------------------------------------------------------------
module encoder_period_tachometer_tb;
  import etp_pkg::*;

  localparam logic MODE_EDGE   = 1'b0;
  localparam logic MODE_STROBE = 1'b1;

  // Indexes past the register list, which the block must ignore.
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_B = 3'd7;

  localparam int RX_HOLD_CYCLES = 1500;
  localparam int SETTLE_CYCLES  = 200;

  // Result word layout, highest field first.
  typedef struct packed {
    logic               pulse_live;
    logic [TIME_W-1:0]  window_pulses;
    logic [TIME_W-1:0]  bad_intervals;
    logic [TIME_W-1:0]  pulse_total;
    logic [TIME_W-1:0]  interval_us;
    logic [SPEED_W-1:0] avg_rpm;
    logic [SPEED_W-1:0] inst_rpm;
  } readout_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [S_TDATA_W-1:0]  s_axis_tdata_i;
  logic                  s_axis_tuser_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [M_TDATA_W-1:0]  m_axis_tdata_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Register copies.
  logic [TIME_W-1:0]  min_gap_us;
  logic [TIME_W-1:0]  max_gap_us;
  logic [TIME_W-1:0]  stale_us;
  logic [NUM_W-1:0]   rpm_scale;
  logic [SAMP_W-1:0]  avg_len;
  logic [TIME_W-1:0]  win_len_us;

  // Tachometer state.
  logic [TIME_W-1:0]  last_edge_us;
  logic               have_edge;
  logic [TIME_W-1:0]  gap_us;
  logic [SPEED_W-1:0] speed_q8;
  logic [TIME_W-1:0]  good_edge_us;
  logic [TIME_W-1:0]  edge_count;
  logic [TIME_W-1:0]  reject_count;
  logic [TIME_W-1:0]  win_count;
  logic [TIME_W-1:0]  win_start_us;
  logic [SPEED_W-1:0] speed_ring_q8 [AVG_DEPTH];
  int                 ring_wr;
  logic               ring_wrapped;
  logic [SPEED_W-1:0] avg_q8;

  readout_t          readout_q [$];
  int                fail_count;
  int                tx_burst_left;
  bit                no_idle;
  bit                rx_hold;
  logic [TIME_W-1:0] stamp_us;

  encoder_period_tachometer i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #20ms;
    $display("encoder_period_tachometer: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Behavioral tachometer
  // ---------------------------------------------------------------------------
  function automatic void reset_tach_model();
    min_gap_us   = MIN_INT_RST;
    max_gap_us   = MAX_INT_RST;
    stale_us     = TIMEOUT_RST;
    rpm_scale    = NUMER_RST;
    avg_len      = SAMPLES_RST;
    win_len_us   = WINDOW_RST;
    last_edge_us = '0;
    have_edge    = 1'b0;
    gap_us       = '0;
    speed_q8     = '0;
    good_edge_us = '0;
    edge_count   = '0;
    reject_count = '0;
    win_count    = '0;
    win_start_us = '0;
    foreach (speed_ring_q8[i]) speed_ring_q8[i] = '0;
    ring_wr      = 0;
    ring_wrapped = 1'b0;
    avg_q8       = '0;
  endfunction

  function automatic void set_tach_reg(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_MIN_INTERVAL: min_gap_us = val;
      REG_MAX_INTERVAL: max_gap_us = val;
      REG_TIMEOUT:      stale_us   = val;
      REG_RPM_NUMER:    rpm_scale  = val[NUM_W-1:0];
      REG_AVG_SAMPLES:  avg_len    = val[SAMP_W-1:0];
      REG_WINDOW:       win_len_us = val;
      default: ;
    endcase
  endfunction

  function automatic logic [SPEED_W-1:0] speed_for_gap(input logic [TIME_W-1:0] gap);
    logic [63:0] q;
    if (gap == '0) return SPEED_MAX;
    q = (64'(rpm_scale) << FRAC_W) / 64'(gap);
    return (q > 64'(SPEED_MAX)) ? SPEED_MAX : q[SPEED_W-1:0];
  endfunction

  function automatic readout_t advance_tach(input logic mode, input logic [TIME_W-1:0] now_us);
    readout_t          r;
    logic [TIME_W-1:0] dt;
    logic [TIME_W-1:0] since_good;
    logic [63:0]       sum;
    int                n;
    int                cnt;
    if (mode == MODE_EDGE) begin
      edge_count = edge_count + 1'b1;
      if (have_edge) begin
        dt = now_us - last_edge_us;
        if (dt >= min_gap_us && dt <= max_gap_us) begin
          gap_us       = dt;
          speed_q8     = speed_for_gap(dt);
          good_edge_us = now_us;
        end else begin
          reject_count = reject_count + 1'b1;
        end
      end
      last_edge_us = now_us;
      have_edge    = 1'b1;
      dt = now_us - win_start_us;
      if (dt >= win_len_us) begin
        win_count    = '0;
        win_start_us = now_us;
      end
      win_count = win_count + 1'b1;
    end else begin
      n = avg_len;
      if (n < 1) n = 1;
      if (n > AVG_DEPTH) n = AVG_DEPTH;
      since_good = now_us - good_edge_us;
      if (since_good > stale_us) speed_q8 = '0;
      speed_ring_q8[ring_wr % AVG_DEPTH] = speed_q8;
      ring_wr = (ring_wr + 1) % n;
      if (ring_wr == 0) ring_wrapped = 1'b1;
      // The pointer may sit past a shrunken sample count; the average still
      // covers only the low entries.
      cnt = ring_wrapped ? n : ring_wr;
      sum = '0;
      for (int i = 0; i < cnt; i++) sum += speed_ring_q8[i];
      avg_q8 = (cnt > 0) ? SPEED_W'(sum / 64'(cnt)) : '0;
    end
    since_good      = now_us - good_edge_us;
    r.inst_rpm      = speed_q8;
    r.avg_rpm       = avg_q8;
    r.interval_us   = gap_us;
    r.pulse_total   = edge_count;
    r.bad_intervals = reject_count;
    r.window_pulses = win_count;
    r.pulse_live    = (since_good <= stale_us);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    readout_t got;
    readout_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[OUT_BITS-1:0];
      if (readout_q.size() == 0) begin
        $display("%0t ns: result word with nothing pending, expected none, got 0x%0h",
                 $time, m_axis_tdata_o);
        fail_count++;
      end else begin
        want = readout_q.pop_front();
        check_field("inst_rpm", 32'(want.inst_rpm), 32'(got.inst_rpm));
        check_field("avg_rpm", 32'(want.avg_rpm), 32'(got.avg_rpm));
        check_field("interval_us", want.interval_us, got.interval_us);
        check_field("pulse_total", want.pulse_total, got.pulse_total);
        check_field("bad_intervals", want.bad_intervals, got.bad_intervals);
        check_field("window_pulses", want.window_pulses, got.window_pulses);
        check_field("pulse_live", 32'(want.pulse_live), 32'(got.pulse_live));
        check_field("zero fill", '0, 32'(m_axis_tdata_o[M_TDATA_W-1:OUT_BITS]));
      end
    end
  end

  // Output side pacing: random ready runs and stalls, a long hold on request.
  initial begin : rx_pacing
    int ready_run;
    int stall_run;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_hold) begin
        m_axis_tready_i <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        rx_hold = 1'b0;
      end else if (no_idle) begin
        m_axis_tready_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        ready_run = $urandom_range(1, 24);
        stall_run = ($urandom_range(3) == 0) ? $urandom_range(30, 90) : $urandom_range(0, 6);
        m_axis_tready_i <= 1'b1;
        repeat (ready_run) @(posedge clk_i);
        if (stall_run > 0) begin
          m_axis_tready_i <= 1'b0;
          repeat (stall_run) @(posedge clk_i);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    set_tach_reg(idx, val);
    @(posedge clk_i);
  endtask

  // Offers one word and returns once it is taken, after a random gap at a burst's
  // end. Valid stays high within a burst, so the next word follows without a gap.
  task automatic send_word(input logic mode, input logic [TIME_W-1:0] now_us);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= mode;
    s_axis_tdata_i  <= now_us;
    do @(posedge clk_i); while (!s_axis_tready_o);
    readout_q.push_back(advance_tach(mode, now_us));
    if (!no_idle && tx_burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      tx_burst_left = $urandom_range(0, 12);
    end else if (tx_burst_left > 0) begin
      tx_burst_left--;
    end
  endtask

  // Must be called in the step of the last handshake.
  task automatic stop_sending();
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic wait_results_drained();
    while (readout_q.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_default_registers();
    send_word(MODE_STROBE, 32'd100);      // strobe before any pulse
    send_word(MODE_EDGE, 32'd1000);       // first edge only counts
    send_word(MODE_EDGE, 32'd1000);       // zero interval, under the window
    send_word(MODE_EDGE, 32'd1017);       // shortest accepted interval
    send_word(MODE_EDGE, 32'd1001017);    // longest accepted interval
    send_word(MODE_EDGE, 32'd2001017);    // rate window expires exactly here
    send_word(MODE_EDGE, 32'd3001018);    // one past the longest, speed kept
    send_word(MODE_STROBE, 32'd3001018);  // stale speed drops to zero
    send_word(MODE_EDGE, 32'd3002018);
    send_word(MODE_STROBE, 32'd3502018);  // exactly at the timeout
    send_word(MODE_STROBE, 32'd3502019);  // one past it
    send_word(MODE_STROBE, 32'd3502020);
    send_word(MODE_STROBE, 32'd3502021);  // oldest entry overwritten
    send_word(MODE_EDGE, 32'hFFFF_FFF0);
    send_word(MODE_EDGE, 32'h0000_0010);  // interval across the timestamp wrap
    send_word(MODE_STROBE, 32'h0000_0020);
    stop_sending();
    wait_results_drained();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_MIN_INTERVAL, '0);
    write_reg(REG_MAX_INTERVAL, '1);
    write_reg(REG_TIMEOUT, '1);
    write_reg(REG_RPM_NUMER, '1);
    write_reg(REG_AVG_SAMPLES, '0);
    write_reg(REG_WINDOW, '0);
    write_reg(SPARE_IDX_A, '1);
    write_reg(SPARE_IDX_B, 32'h5A5A_A5A5);
    send_word(MODE_EDGE, 32'd5000);
    send_word(MODE_EDGE, 32'd5000);       // zero interval saturates
    send_word(MODE_EDGE, 32'd5001);
    send_word(MODE_STROBE, 32'd5002);
    send_word(MODE_EDGE, 32'd4999);       // interval of all ones but the lowest bit
    stop_sending();
    wait_results_drained();

    // An empty accept window, a zero timeout and a zero numerator.
    write_reg(REG_MIN_INTERVAL, '1);
    write_reg(REG_MAX_INTERVAL, '0);
    write_reg(REG_TIMEOUT, '0);
    write_reg(REG_RPM_NUMER, '0);
    write_reg(REG_AVG_SAMPLES, '1);
    write_reg(REG_WINDOW, '1);
    send_word(MODE_EDGE, 32'd6000);
    send_word(MODE_STROBE, good_edge_us);
    send_word(MODE_STROBE, good_edge_us + 1'b1);
    stop_sending();
    wait_results_drained();
    write_reg(REG_MIN_INTERVAL, '0);
    write_reg(REG_MAX_INTERVAL, '1);
    send_word(MODE_EDGE, 32'd7000);
    stop_sending();
    wait_results_drained();
    stamp_us = 32'd7000;
  endtask

  // The receiver holds off while words keep coming, so the block backs up.
  task automatic test_output_backpressure();
    int k;
    no_idle = 1'b1;
    rx_hold = 1'b1;
    for (k = 0; k < 40; k++) begin
      stamp_us = stamp_us + 500 + $urandom_range(0, 100);
      send_word((k % 3 == 2) ? MODE_STROBE : MODE_EDGE, stamp_us);
    end
    stop_sending();
    wait_results_drained();
    no_idle = 1'b0;
  endtask

  task automatic run_random_phase(input bit write_all, input int n_words);
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
    logic [TIME_W-1:0] jitter;
    int                pick;
    case ($urandom_range(2))
      0:       period = $urandom_range(17, 400);
      1:       period = $urandom_range(400, 20000);
      default: period = $urandom_range(20000, 900000);
    endcase
    if ($urandom_range(7) == 0) begin
      lo = $urandom();
      hi = $urandom();
    end else begin
      lo = period - $urandom_range(0, period / 2);
      hi = period + $urandom_range(0, period);
    end
    if (write_all || $urandom_range(3) != 0) write_reg(REG_MIN_INTERVAL, lo);
    if (write_all || $urandom_range(3) != 0) write_reg(REG_MAX_INTERVAL, hi);
    if (write_all || $urandom_range(3) != 0)
      write_reg(REG_TIMEOUT,
                ($urandom_range(5) == 0) ? $urandom() : period * $urandom_range(1, 8));
    if (write_all || $urandom_range(3) != 0)
      write_reg(REG_RPM_NUMER,
                ($urandom_range(5) == 0) ? $urandom() : $urandom_range(1, 60000000));
    if (write_all || $urandom_range(3) != 0)
      write_reg(REG_AVG_SAMPLES,
                ($urandom_range(5) == 0) ? $urandom() : $urandom_range(1, AVG_DEPTH));
    if (write_all || $urandom_range(3) != 0)
      write_reg(REG_WINDOW,
                ($urandom_range(5) == 0) ? $urandom() : period * $urandom_range(1, 50));
    if ($urandom_range(3) == 0) stamp_us = 32'hFFFF_FFFF - period * $urandom_range(0, 30);
    no_idle = ($urandom_range(3) == 0);

    repeat (n_words) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        jitter   = $urandom_range(0, period / 4);
        stamp_us = stamp_us + period + jitter - period / 8;
        send_word(MODE_EDGE, stamp_us);
      end else if (pick < 80) begin
        stamp_us = stamp_us + $urandom_range(0, period / 4);
        send_word(MODE_STROBE, stamp_us);
      end else if (pick < 87) begin
        // Contact bounce: an edge far too soon after the last one.
        stamp_us = stamp_us + $urandom_range(0, period / 8);
        send_word(MODE_EDGE, stamp_us);
      end else if (pick < 94) begin
        // The shaft stalls for a while.
        stamp_us = stamp_us + period * $urandom_range(2, 12);
        send_word(logic'($urandom_range(1)), stamp_us);
      end else begin
        send_word(logic'($urandom_range(1)), $urandom());
      end
    end
    stop_sending();
    wait_results_drained();
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = MODE_EDGE;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_MIN_INTERVAL;
    cfg_data_i      = '0;
    rst_ni          = 1'b0;
    fail_count      = 0;
    tx_burst_left   = 0;
    no_idle         = 1'b0;
    rx_hold         = 1'b0;
    stamp_us        = '0;
    reset_tach_model();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_registers();
    test_register_extremes();
    run_random_phase(1'b1, $urandom_range(85, 115));
    test_output_backpressure();
    repeat (11) run_random_phase(1'b0, $urandom_range(85, 115));

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && readout_q.size() == 0) begin
      $display("encoder_period_tachometer: match");
    end else begin
      $display("encoder_period_tachometer: mismatch");
    end
    $finish;
  end

endmodule
